// ----- design/mwa_pkg.sv -----
// types and constants shared by the max weight assignment block
package mwa_pkg;

    localparam int ENTRY_W     = 32;
    localparam int SCORE_W     = 35;
    localparam int BEST_W      = 34;
    localparam int COUNT_W     = 4;
    localparam int CFG_INDEX_W = 2;
    localparam int S_TDATA_W   = 32;
    localparam int M_TDATA_W   = 40;

    localparam logic [CFG_INDEX_W-1:0] CFG_ROW_COUNT    = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_COLUMN_COUNT = 2'd1;

    localparam logic [COUNT_W-1:0] ROW_COUNT_RESET    = 4'd8;
    localparam logic [COUNT_W-1:0] COLUMN_COUNT_RESET = 4'd8;

    typedef enum logic [2:0] {
        ST_LOAD,
        ST_CLEAR,
        ST_SCAN,
        ST_DRAIN,
        ST_READ_FULL,
        ST_DONE
    } mwa_state_t;

    typedef struct packed {
        logic take_base;
        logic take_cand;
        logic clear;
        logic out_load;
        logic out_zero;
    } mwa_ctrl_t;

endpackage

// ----- design/mwa_ram.sv -----
// generic single write port ram with registered read
module mwa_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                                        aclk,
    input  logic                                        we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                            wdata,
    input  logic                                        re,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                            rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ----- design/mwa_seq.sv -----
// sequencer: matrix loading, table clearing and the row by mask search order
module mwa_seq
    import mwa_pkg::*;
#(
    parameter int MAX_ROWS    = 8,
    parameter int MAX_COLUMNS = 8,
    localparam int RW  = $clog2(MAX_ROWS + 1),
    localparam int CW  = $clog2(MAX_COLUMNS + 1),
    localparam int SD  = MAX_ROWS * MAX_COLUMNS,
    localparam int SAW = (SD > 1) ? $clog2(SD) : 1,
    localparam int PW  = $clog2(SD + 1),
    localparam int MW  = MAX_COLUMNS
) (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic [RW-1:0]  rows_used,
    input  logic [CW-1:0]  cols_used,
    input  logic           in_valid,
    input  logic           in_last,
    output logic           in_ready,
    input  logic           out_free,
    output logic           store_we,
    output logic [SAW-1:0] store_waddr,
    output logic           w_re,
    output logic [SAW-1:0] w_raddr,
    output logic           dp_re,
    output logic [MW-1:0]  dp_raddr,
    output logic           dp_we,
    output logic [MW-1:0]  dp_waddr,
    output mwa_ctrl_t      ctrl
);

    mwa_state_t state_reg, state_next;
    logic [PW-1:0] pos_reg, pos_next;
    logic [RW-1:0] r_reg, r_next;
    logic [CW-1:0] c_reg, c_next;
    logic [MW-1:0] full_reg, full_next;
    logic          zero_reg, zero_next;
    logic [MW-1:0] msk_reg, msk_next;
    logic [MW-1:0] bit_reg, bit_next;
    logic [RW-1:0] k_reg, k_next;
    logic [CW-1:0] t_reg, t_next;
    logic [PW-1:0] row_base_reg, row_base_next;
    logic [PW-1:0] w_addr_reg, w_addr_next;
    logic          rd_base_reg, rd_base_next;
    logic          rd_cand_reg, rd_cand_next;

    logic [PW-1:0] total;
    logic          accept;
    logic          store_ok;

    assign total    = PW'(rows_used) * PW'(cols_used);
    assign accept   = in_valid && (state_reg == ST_LOAD);
    assign store_ok = (pos_reg < total) && (32'(pos_reg) < SD);

    always_comb begin
        state_next    = state_reg;
        pos_next      = pos_reg;
        r_next        = r_reg;
        c_next        = c_reg;
        full_next     = full_reg;
        zero_next     = zero_reg;
        msk_next      = msk_reg;
        bit_next      = bit_reg;
        k_next        = k_reg;
        t_next        = t_reg;
        row_base_next = row_base_reg;
        w_addr_next   = w_addr_reg;
        rd_base_next  = (state_reg == ST_SCAN) && (t_reg == '0);
        rd_cand_next  = (state_reg == ST_SCAN) && (t_reg != '0) && (|(msk_reg & bit_reg));
        unique case (state_reg)
            ST_LOAD: begin
                if (accept) begin
                    if (store_ok) begin
                        pos_next = pos_reg + PW'(1);
                    end
                    if (in_last) begin
                        pos_next   = '0;
                        r_next     = rows_used;
                        c_next     = cols_used;
                        full_next  = MW'((1 << cols_used) - 1);
                        zero_next  = (rows_used == '0) || (cols_used == '0);
                        msk_next   = '0;
                        state_next = ((rows_used == '0) || (cols_used == '0)) ? ST_DONE
                                                                              : ST_CLEAR;
                    end
                end
            end
            ST_CLEAR: begin
                if (msk_reg == full_reg) begin
                    k_next        = '0;
                    row_base_next = '0;
                    t_next        = '0;
                    state_next    = ST_SCAN;
                end else begin
                    msk_next = msk_reg + MW'(1);
                end
            end
            ST_SCAN: begin
                if (t_reg == '0) begin
                    bit_next    = MW'(1);
                    w_addr_next = row_base_reg;
                end else begin
                    bit_next    = bit_reg << 1;
                    w_addr_next = w_addr_reg + PW'(1);
                end
                t_next = t_reg + CW'(1);
                if (t_reg == c_reg) begin
                    t_next     = '0;
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN: begin
                t_next = '0;
                if (msk_reg == '0) begin
                    if ((k_reg + RW'(1)) == r_reg) begin
                        state_next = ST_READ_FULL;
                    end else begin
                        k_next        = k_reg + RW'(1);
                        row_base_next = row_base_reg + PW'(c_reg);
                        msk_next      = full_reg;
                        state_next    = ST_SCAN;
                    end
                end else begin
                    msk_next   = msk_reg - MW'(1);
                    state_next = ST_SCAN;
                end
            end
            ST_READ_FULL: begin
                state_next = ST_DONE;
            end
            ST_DONE: begin
                if (out_free) begin
                    state_next = ST_LOAD;
                end
            end
            default: begin
                state_next = ST_LOAD;
            end
        endcase
    end

    always_comb begin
        in_ready       = (state_reg == ST_LOAD);
        store_we       = accept && store_ok;
        store_waddr    = SAW'(pos_reg);
        w_re           = (state_reg == ST_SCAN) && (t_reg != '0);
        w_raddr        = SAW'(w_addr_reg);
        dp_re          = (state_reg == ST_SCAN) || (state_reg == ST_READ_FULL);
        if (state_reg == ST_READ_FULL) begin
            dp_raddr = full_reg;
        end else if (t_reg == '0) begin
            dp_raddr = msk_reg;
        end else begin
            dp_raddr = msk_reg ^ bit_reg;
        end
        dp_we          = (state_reg == ST_CLEAR) || (state_reg == ST_DRAIN);
        dp_waddr       = msk_reg;
        ctrl.take_base = rd_base_reg;
        ctrl.take_cand = rd_cand_reg;
        ctrl.clear     = (state_reg == ST_CLEAR);
        ctrl.out_load  = (state_reg == ST_DONE) && out_free;
        ctrl.out_zero  = zero_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_LOAD;
            pos_reg      <= '0;
            r_reg        <= '0;
            c_reg        <= '0;
            full_reg     <= '0;
            zero_reg     <= 1'b0;
            msk_reg      <= '0;
            bit_reg      <= '0;
            k_reg        <= '0;
            t_reg        <= '0;
            row_base_reg <= '0;
            w_addr_reg   <= '0;
            rd_base_reg  <= 1'b0;
            rd_cand_reg  <= 1'b0;
        end else begin
            state_reg    <= state_next;
            pos_reg      <= pos_next;
            r_reg        <= r_next;
            c_reg        <= c_next;
            full_reg     <= full_next;
            zero_reg     <= zero_next;
            msk_reg      <= msk_next;
            bit_reg      <= bit_next;
            k_reg        <= k_next;
            t_reg        <= t_next;
            row_base_reg <= row_base_next;
            w_addr_reg   <= w_addr_next;
            rd_base_reg  <= rd_base_next;
            rd_cand_reg  <= rd_cand_next;
        end
    end

endmodule

// ----- design/max_weight_assignment.sv -----
// top level: maximum weight partial assignment over a loaded weight matrix
//
//   channel  dir  handshake             payload
//   s_       in   s_tvalid/s_tready     s_tdata entry_value, s_tlast entry_last
//   m_       out  m_tvalid/m_tready     m_tdata best_weight
//   cfg_     in   cfg_valid/cfg_ready   cfg_index, cfg_data
//
// each matrix entry takes one cycle; the last entry starts the search, which first clears
// the mask table, then does the table updates for each row (per mask one base read,
// one read per column and a write-back) and then reads the full mask result to finish.
// aresetn is synchronous; the mask table and weight store are not cleared by it.
// no entry is taken during a search; a result waiting on m_tready only stalls the
// next search at its end.
module max_weight_assignment
    import mwa_pkg::*;
#(
    parameter int MAX_ROWS    = 8,
    parameter int MAX_COLUMNS = 8
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   s_tvalid,
    output logic                   s_tready,
    input  logic [S_TDATA_W-1:0]   s_tdata,   // [31:0] entry_value
    input  logic                   s_tlast,
    output logic                   m_tvalid,
    input  logic                   m_tready,
    output logic [M_TDATA_W-1:0]   m_tdata,   // [33:0] best_weight, [39:34] zero
    input  logic                   cfg_valid,
    output logic                   cfg_ready,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [COUNT_W-1:0]     cfg_data
);

    localparam int RW  = $clog2(MAX_ROWS + 1);
    localparam int CW  = $clog2(MAX_COLUMNS + 1);
    localparam int SD  = MAX_ROWS * MAX_COLUMNS;
    localparam int SAW = (SD > 1) ? $clog2(SD) : 1;
    localparam int MD  = 1 << MAX_COLUMNS;
    localparam int MW  = MAX_COLUMNS;

    logic [COUNT_W-1:0] row_count_reg;
    logic [COUNT_W-1:0] column_count_reg;
    logic [RW-1:0]      rows_used;
    logic [CW-1:0]      cols_used;

    logic               store_we;
    logic [SAW-1:0]     store_waddr;
    logic               w_re;
    logic [SAW-1:0]     w_raddr;
    logic [ENTRY_W-1:0] w_rdata;
    logic               dp_re;
    logic [MW-1:0]      dp_raddr;
    logic               dp_we;
    logic [MW-1:0]      dp_waddr;
    logic [SCORE_W-1:0] dp_wdata;
    logic [SCORE_W-1:0] dp_rdata;
    mwa_ctrl_t          ctrl;

    logic [SCORE_W-1:0] best_reg, best_next;
    logic [SCORE_W:0]   cand;
    logic               cand_gt;
    logic               m_tvalid_reg;
    logic [BEST_W-1:0]  best_out_reg;
    logic               out_free;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            row_count_reg    <= ROW_COUNT_RESET;
            column_count_reg <= COLUMN_COUNT_RESET;
        end else if (cfg_valid) begin
            unique case (cfg_index)
                CFG_ROW_COUNT:    row_count_reg    <= cfg_data;
                CFG_COLUMN_COUNT: column_count_reg <= cfg_data;
                default: begin
                end
            endcase
        end
    end

    assign rows_used = (32'(row_count_reg) > MAX_ROWS) ? RW'(MAX_ROWS) : RW'(row_count_reg);
    assign cols_used = (32'(column_count_reg) > MAX_COLUMNS) ? CW'(MAX_COLUMNS)
                                                             : CW'(column_count_reg);

    assign out_free = !m_tvalid_reg || m_tready;

    mwa_seq #(
        .MAX_ROWS    (MAX_ROWS),
        .MAX_COLUMNS (MAX_COLUMNS)
    ) u_seq (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .rows_used   (rows_used),
        .cols_used   (cols_used),
        .in_valid    (s_tvalid),
        .in_last     (s_tlast),
        .in_ready    (s_tready),
        .out_free    (out_free),
        .store_we    (store_we),
        .store_waddr (store_waddr),
        .w_re        (w_re),
        .w_raddr     (w_raddr),
        .dp_re       (dp_re),
        .dp_raddr    (dp_raddr),
        .dp_we       (dp_we),
        .dp_waddr    (dp_waddr),
        .ctrl        (ctrl)
    );

    mwa_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (SD)
    ) u_weight_store (
        .aclk  (aclk),
        .we    (store_we),
        .waddr (store_waddr),
        .wdata (s_tdata[ENTRY_W-1:0]),
        .re    (w_re),
        .raddr (w_raddr),
        .rdata (w_rdata)
    );

    mwa_ram #(
        .WIDTH (SCORE_W),
        .DEPTH (MD)
    ) u_best_by_mask (
        .aclk  (aclk),
        .we    (dp_we),
        .waddr (dp_waddr),
        .wdata (dp_wdata),
        .re    (dp_re),
        .raddr (dp_raddr),
        .rdata (dp_rdata)
    );

    // table entries never go below zero, weights are signed
    assign cand    = {1'b0, dp_rdata} + {{(SCORE_W + 1 - ENTRY_W){w_rdata[ENTRY_W-1]}}, w_rdata};
    assign cand_gt = $signed(cand) > $signed({1'b0, best_reg});

    always_comb begin
        priority if (ctrl.take_base) begin
            best_next = dp_rdata;
        end else if (ctrl.take_cand && cand_gt) begin
            best_next = cand[SCORE_W-1:0];
        end else begin
            best_next = best_reg;
        end
    end

    assign dp_wdata = ctrl.clear ? '0 : best_next;

    always_ff @(posedge aclk) begin
        best_reg <= best_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (ctrl.out_load) begin
            m_tvalid_reg <= 1'b1;
        end else if (m_tready) begin
            m_tvalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (ctrl.out_load) begin
            best_out_reg <= ctrl.out_zero ? '0 : dp_rdata[BEST_W-1:0];
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {{(M_TDATA_W - BEST_W){1'b0}}, best_out_reg};

endmodule

// ----- design/mwa_checker.sv -----
// port level checks for the max weight assignment block, bound to the top level
module mwa_checker
    import mwa_pkg::*;
(
    input logic                   aclk,
    input logic                   aresetn,
    input logic                   s_tvalid,
    input logic                   s_tready,
    input logic                   s_tlast,
    input logic                   m_tvalid,
    input logic                   m_tready,
    input logic [M_TDATA_W-1:0]   m_tdata
);

    // a stalled result holds
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result changed while stalled");

    // a last entry starts a search, so no entry is taken next cycle
    a_busy_after_last: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready && s_tlast |=> !s_tready)
        else $error("entry taken right after last entry");

    // a new result only comes out of a search
    a_result_from_search: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_tvalid) |-> $past(!s_tready))
        else $error("result without a search");

    // padding bits above the weight stay zero
    a_pad_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> m_tdata[M_TDATA_W-1:BEST_W] == '0)
        else $error("nonzero padding in result");

endmodule

bind max_weight_assignment mwa_checker u_mwa_checker (.*);
